[rtl/core/psbr_pkg.sv]
// ----------------------------------------------------------------------------
// psbr_pkg: shared types and constants of the bar code reader
// Reader phase encoding, element and code widths, divide-by-three constant.
// ----------------------------------------------------------------------------
package psbr_pkg;

	localparam int unsigned PosW   = 32;
	localparam int unsigned ElemW  = 7;
	localparam int unsigned CodeW  = 11;
	localparam int unsigned CountW = 4;

	// edges in the header and guard pattern, sample points per element
	localparam logic [CountW-1:0] HdrEdges   = 4'd3;
	localparam logic [CountW-1:0] ElemPoints = 4'd8;

	// ceil(2^33 / 3): (x * DivThreeMul) >> 33 equals x / 3 for any 32-bit x
	localparam logic [PosW-1:0] DivThreeMul = 32'hAAAA_AAAB;
	localparam int unsigned     DivThreeSh  = 33;

	localparam logic CmdSample = 1'b0;
	localparam logic CmdArm    = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_SEARCH_HDR = 3'd1,
		PH_PROC_HDR   = 3'd2,
		PH_SEARCH_GRD = 3'd3,
		PH_PROC_GRD   = 3'd4,
		PH_ELEM_A     = 3'd5,
		PH_ELEM_C     = 3'd6
	} phase_t;

endpackage

[rtl/core/psbr_if.sv]
// ----------------------------------------------------------------------------
// psbr channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface psbr_cmd_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        level;
	logic [31:0] position;

	modport source (output valid, kind, level, position, input ready);
	modport sink   (input valid, kind, level, position, output ready);
endinterface

interface psbr_res_if;
	logic        valid;
	logic        ready;
	logic        ready_res;
	logic [10:0] code;

	modport source (output valid, ready_res, code, input ready);
	modport sink   (input valid, ready_res, code, output ready);
endinterface

interface psbr_cfg_if;
	logic valid;
	logic ready;
	logic double_code;

	modport source (output valid, double_code, input ready);
	modport sink   (input valid, double_code, output ready);
endinterface

[rtl/core/position_sampled_barcode_reader_unit.sv]
// ----------------------------------------------------------------------------
// position_sampled_barcode_reader_unit: position sampled bar code reader
// Header/guard measurement, bar interval by three, seven-bit element sampling.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one request per sensor event. kind=1 arms the reader (clears both
//         elements, restarts the header search); kind=0 carries a sensor
//         level and the travelled position (signed, wraps at 32 bits).
//   res : exactly one result per request, in order: ready_res=1 and the
//         decoded code once the reader is idle again, else ready_res=0, code=0.
//   cfg : one-bit double_code write, always accepted; write it while idle.
// Path: an accepted request enters the input register, then the result register
//   is updated together with reader state.
// Throughput: one request per cycle unless res stalls. The limit is the single
//   stage that updates reader state: the divide by three (one 32x32 reciprocal
//   multiply) and the sample-point add sit between input and result registers.
// Reset: reader idle, all state zero, double_code 0, both channels empty.
// Stall: when res.ready is low the result register holds; one more request
//   is taken into the input register, then cmd.ready drops until res drains.
// ----------------------------------------------------------------------------
module position_sampled_barcode_reader_unit
	import psbr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	psbr_cmd_if.sink   cmd,
	psbr_res_if.source res,
	psbr_cfg_if.sink   cfg
);

	// input register
	logic            valid_s1;
	logic            kind_s1;
	logic            level_s1;
	logic [PosW-1:0] position_s1;

	// reader state
	phase_t            phase_q;
	logic [CountW-1:0] edges_left_q;
	logic              last_level_q;
	logic [PosW-1:0]   start_pos_q;
	logic [PosW-1:0]   bar_interval_q;
	logic [PosW-1:0]   next_sample_q;
	logic [ElemW-1:0]  element_a_q;
	logic [ElemW-1:0]  element_c_q;
	logic              double_code_q;

	// result register
	logic             res_valid_q;
	logic             ready_res_q;
	logic [CodeW-1:0] code_q;

	// next state
	phase_t            phase_d;
	logic [CountW-1:0] edges_left_d;
	logic              last_level_d;
	logic [PosW-1:0]   start_pos_d;
	logic [PosW-1:0]   bar_interval_d;
	logic [PosW-1:0]   next_sample_d;
	logic [ElemW-1:0]  element_a_d;
	logic [ElemW-1:0]  element_c_d;

	logic             ready_res_d;
	logic [CodeW-1:0] code_d;

	logic advance;

	// interval datapath
	logic [PosW-1:0]   pos_diff;
	logic              dist_neg;
	logic [PosW-1:0]   dist_mag;
	logic [2*PosW-1:0] div_prod;
	logic [PosW-1:0]   quot_mag;
	logic [PosW-1:0]   interval_new;
	logic [PosW-1:0]   half_new;
	logic [PosW-1:0]   half_cur;
	logic [CountW-1:0] edges_dec;
	logic              sample_due;

	// stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid     = res_valid_q;
	assign res.ready_res = ready_res_q;
	assign res.code      = code_q;

	// signed distance / 3, truncated toward zero: divide the magnitude
	assign pos_diff = position_s1 - start_pos_q;
	assign dist_neg = pos_diff[PosW-1];
	assign dist_mag = dist_neg ? (-pos_diff) : pos_diff;
	assign div_prod = {{PosW{1'b0}}, dist_mag} * {{PosW{1'b0}}, DivThreeMul};
	assign quot_mag = {1'b0, div_prod[2*PosW-1:DivThreeSh]};
	assign interval_new = dist_neg ? (-quot_mag) : quot_mag;

	// half interval, arithmetic shift
	assign half_new = {interval_new[PosW-1], interval_new[PosW-1:1]};
	assign half_cur = {bar_interval_q[PosW-1], bar_interval_q[PosW-1:1]};

	assign edges_dec  = edges_left_q - CountW'(1);
	assign sample_due = $signed(position_s1) >= $signed(next_sample_q);

	// next-state logic
	always_comb begin
		phase_d        = phase_q;
		edges_left_d   = edges_left_q;
		last_level_d   = last_level_q;
		start_pos_d    = start_pos_q;
		bar_interval_d = bar_interval_q;
		next_sample_d  = next_sample_q;
		element_a_d    = element_a_q;
		element_c_d    = element_c_q;
		if (kind_s1 == CmdArm) begin
			phase_d     = PH_SEARCH_HDR;
			element_a_d = '0;
			element_c_d = '0;
		end else begin
			unique case (phase_q)
				PH_SEARCH_HDR, PH_SEARCH_GRD: begin
					if (level_s1) begin
						start_pos_d  = position_s1;
						last_level_d = 1'b1;
						edges_left_d = HdrEdges;
						phase_d      = (phase_q == PH_SEARCH_HDR) ? PH_PROC_HDR : PH_PROC_GRD;
					end
				end
				PH_PROC_HDR, PH_PROC_GRD: begin
					if (level_s1 != last_level_q) begin
						last_level_d = level_s1;
						edges_left_d = edges_dec;
						if (edges_dec == '0) begin
							bar_interval_d = interval_new;
							edges_left_d   = ElemPoints;
							if (phase_q == PH_PROC_HDR) begin
								next_sample_d = position_s1 + half_new;
								phase_d       = PH_ELEM_A;
							end else begin
								// skip the guard's trailing bar
								next_sample_d = position_s1 + half_new + interval_new;
								phase_d       = PH_ELEM_C;
							end
						end
					end
				end
				PH_ELEM_A, PH_ELEM_C: begin
					if (sample_due) begin
						next_sample_d = position_s1 + half_cur;
						edges_left_d  = edges_dec;
						if (edges_dec == '0) begin
							// eighth point closes the element
							if (!double_code_q || phase_q == PH_ELEM_C) begin
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_SEARCH_GRD;
							end
						end else if (phase_q == PH_ELEM_A) begin
							element_a_d = {element_a_q[ElemW-2:0], level_s1};
						end else begin
							element_c_d = {element_c_q[ElemW-2:0], level_s1};
						end
					end
				end
				default: begin
					// idle: samples are dropped
				end
			endcase
		end
	end

	// result logic, from the updated state
	always_comb begin
		ready_res_d = 1'b0;
		code_d      = '0;
		if (phase_d == PH_IDLE) begin
			ready_res_d = 1'b1;
			if (double_code_q) begin
				code_d = {1'b0, element_a_d, 3'b000} + {3'b000, element_a_d, 1'b0}
					+ {{(CodeW-ElemW){1'b0}}, element_c_d};
			end else begin
				code_d = {{(CodeW-ElemW){1'b0}}, element_a_d};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1     <= cmd.kind;
			level_s1    <= cmd.level;
			position_s1 <= cmd.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_code_q <= 1'b0;
		end else if (cfg.valid) begin
			double_code_q <= cfg.double_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			edges_left_q   <= '0;
			last_level_q   <= 1'b0;
			start_pos_q    <= '0;
			bar_interval_q <= '0;
			next_sample_q  <= '0;
			element_a_q    <= '0;
			element_c_q    <= '0;
		end else if (advance) begin
			phase_q        <= phase_d;
			edges_left_q   <= edges_left_d;
			last_level_q   <= last_level_d;
			start_pos_q    <= start_pos_d;
			bar_interval_q <= bar_interval_d;
			next_sample_q  <= next_sample_d;
			element_a_q    <= element_a_d;
			element_c_q    <= element_c_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ready_res_q <= ready_res_d;
			code_q      <= code_d;
		end
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the position sampled bar code reader
// Drives arm and sensor requests, keeps a cycle-free model of the reader
// state and compares every result in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import psbr_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 60;

	// one expected result of the reader
	typedef struct packed {
		logic             ready_res;
		logic [CodeW-1:0] code;
	} code_report_t;

	// Tracks the reader state per accepted request and holds the results it owes.
	class code_scoreboard;
		phase_t            phase;
		logic [CountW-1:0] edges_left;
		logic              last_level;
		logic [PosW-1:0]   start_pos;
		logic [PosW-1:0]   interval;
		logic [PosW-1:0]   next_point;
		logic [ElemW-1:0]  elem_a;
		logic [ElemW-1:0]  elem_c;
		logic              double_code;
		code_report_t      owed_reports[$];
		int                errors;

		function new();
			phase       = PH_IDLE;
			edges_left  = '0;
			last_level  = 1'b0;
			start_pos   = '0;
			interval    = '0;
			next_point  = '0;
			elem_a      = '0;
			elem_c      = '0;
			double_code = 1'b0;
			errors      = 0;
		endfunction

		function void set_mode(logic v);
			double_code = v;
		endfunction

		function int pending();
			return owed_reports.size();
		endfunction

		// half interval, rounded toward minus infinity
		function logic [PosW-1:0] half_of(logic [PosW-1:0] v);
			logic signed [PosW-1:0] s;
			s = v;
			return s >>> 1;
		endfunction

		function void take_request(logic kind, logic level, logic [PosW-1:0] pos);
			logic signed [PosW-1:0] pos_diff;
			code_report_t           r;
			if (kind == CmdArm) begin
				phase  = PH_SEARCH_HDR;
				elem_a = '0;
				elem_c = '0;
			end else begin
				case (phase)
					PH_SEARCH_HDR, PH_SEARCH_GRD: begin
						if (level) begin
							start_pos  = pos;
							last_level = 1'b1;
							edges_left = HdrEdges;
							phase = (phase == PH_SEARCH_HDR) ? PH_PROC_HDR : PH_PROC_GRD;
						end
					end
					PH_PROC_HDR, PH_PROC_GRD: begin
						if (level != last_level) begin
							last_level = level;
							edges_left = edges_left - CountW'(1);
							if (edges_left == '0) begin
								pos_diff   = pos - start_pos;
								interval   = pos_diff / 3;
								next_point = pos + half_of(interval);
								edges_left = ElemPoints;
								if (phase == PH_PROC_HDR) begin
									phase = PH_ELEM_A;
								end else begin
									next_point = next_point + interval;
									phase      = PH_ELEM_C;
								end
							end
						end
					end
					PH_ELEM_A, PH_ELEM_C: begin
						if ($signed(pos) >= $signed(next_point)) begin
							next_point = pos + half_of(interval);
							edges_left = edges_left - CountW'(1);
							if (edges_left == '0) begin
								if (!double_code || phase == PH_ELEM_C) phase = PH_IDLE;
								else phase = PH_SEARCH_GRD;
							end else if (phase == PH_ELEM_A) begin
								elem_a = {elem_a[ElemW-2:0], level};
							end else begin
								elem_c = {elem_c[ElemW-2:0], level};
							end
						end
					end
					default: ;
				endcase
			end
			if (phase == PH_IDLE) begin
				r.ready_res = 1'b1;
				r.code      = double_code ? CodeW'(elem_a) * 11'd10 + CodeW'(elem_c)
					: CodeW'(elem_a);
			end else begin
				r = '0;
			end
			owed_reports.push_back(r);
		endfunction

		function void check_report(logic ready_res, logic [CodeW-1:0] code);
			code_report_t want;
			if (owed_reports.size() == 0) begin
				$error("result with no request waiting: ready_res %0d code %0d",
					ready_res, code);
				errors++;
				return;
			end
			want = owed_reports.pop_front();
			if (ready_res !== want.ready_res) begin
				$error("ready_res: expected %0d, actual %0d", want.ready_res, ready_res);
				errors++;
			end
			if (code !== want.code) begin
				$error("code: expected %0d, actual %0d", want.code, code);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	psbr_cmd_if cmd_ch();
	psbr_res_if res_ch();
	psbr_cfg_if cfg_ch();

	position_sampled_barcode_reader_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	code_scoreboard sb;

	int   send_idle_pct;   // percent of cycles the request side stays quiet
	int   recv_idle_pct;   // percent of cycles the result side stalls
	bit   rough;           // jitter and filler samples in the read patterns
	bit   hold_active;
	int   counted_items;
	int   cycle_cnt;
	event hold_off_ev;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stalls, forced low during a hold-off
	always @(negedge clk) begin
		res_ch.ready = !hold_active && ($urandom_range(99) >= recv_idle_pct);
	end

	// long hold-off of the result side, counted here in clock cycles
	always begin
		@(hold_off_ev);
		hold_active = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_active = 1'b0;
	end

	// every accepted result is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_report(res_ch.ready_res, res_ch.code);
	end

	// one request; called at a falling edge, returns at a falling edge with valid
	// still high, so back-to-back requests drop valid only in a random idle pause
	task automatic send_request(input logic kind, input logic level,
			input logic [PosW-1:0] pos, input bit counted);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid    = 1'b1;
		cmd_ch.kind     = kind;
		cmd_ch.level    = level;
		cmd_ch.position = pos;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sb.take_request(kind, level, pos);
		if (counted) counted_items++;
		@(negedge clk);
	endtask

	// stop requests until every owed result is back, then let the pipe settle
	task automatic wait_drain();
		cmd_ch.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(input logic v);
		cfg_ch.valid       = 1'b1;
		cfg_ch.double_code = v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.set_mode(v);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// header or guard: high, then three level changes one interval apart
	task automatic send_bars(inout logic [PosW-1:0] pos, input logic [PosW-1:0] iv);
		logic lvl;
		if (rough) repeat ($urandom_range(2)) send_request(CmdSample, 1'b0, $urandom, 1'b1);
		lvl = 1'b1;
		send_request(CmdSample, lvl, pos, 1'b1);
		for (int k = 0; k < 3; k++) begin
			// same-level filler does not count as a change
			if (rough && $urandom_range(3) == 0)
				send_request(CmdSample, lvl, pos + (iv >> 1), 1'b1);
			pos = pos + iv;
			lvl = !lvl;
			send_request(CmdSample, lvl, pos, 1'b1);
		end
	endtask

	// sample points of one element, msb first; the last point carries no bit
	task automatic send_element(inout logic [PosW-1:0] pos, input logic [PosW-1:0] iv,
			input bit after_guard, input logic [ElemW-1:0] elem_bits, input int points);
		logic signed [PosW-1:0] half;
		logic [PosW-1:0]        step;
		half = iv;
		half = half >>> 1;
		for (int k = 0; k < points; k++) begin
			step = (k == 0 && after_guard) ? iv + half : half;
			if (rough && $urandom_range(3) == 0) step = step + $urandom_range(3);
			// early sample below the point, should be skipped
			if (rough && k > 0 && $urandom_range(7) == 0)
				send_request(CmdSample, 1'($urandom_range(1)), pos, 1'b1);
			pos = pos + step;
			send_request(CmdSample,
				(k < ElemW) ? elem_bits[ElemW-1-k] : 1'($urandom_range(1)), pos, 1'b1);
		end
	endtask

	function automatic logic [PosW-1:0] pick_interval();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(2, 300);
		if (r < 80) return $urandom_range(1);
		if (r < 90) return $urandom_range(1, 32'h1000_0000);
		return -$urandom_range(2, 300);
	endfunction

	initial begin : stimulus
		logic [PosW-1:0] pos;
		logic [PosW-1:0] iv;
		logic            mode_now;
		logic            dbl;
		int              points;
		int              next_hold;
		int              next_drain;

		sb                 = new();
		arst_n             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.kind        = CmdSample;
		cmd_ch.level       = 1'b0;
		cmd_ch.position    = '0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.double_code = 1'b0;
		hold_active        = 1'b0;
		send_idle_pct      = 6;
		recv_idle_pct      = 50;
		rough              = 1'b0;
		counted_items      = 0;
		cycle_cnt          = 0;
		mode_now           = 1'b0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// sample while idle: ignored, code of the cleared elements
		send_request(CmdSample, 1'b1, 32'h8000_0000, 1'b1);
		// arm: level and position on an arm item carry no meaning
		send_request(CmdArm, 1'b1, 32'hFFFF_FFFF, 1'b1);
		// header just below the top of the signed range, so sample points wrap
		pos = 32'h7FFF_FFF0;
		send_bars(pos, 32'd4);
		// switch to double mode while the reader is between header and element A
		wait_drain();
		write_mode(1'b1);
		mode_now = 1'b1;
		send_element(pos, 32'd4, 1'b0, 7'h7F, int'(ElemPoints));
		// guard measured backwards: negative interval, floor of the half step
		send_bars(pos, -32'sd5);
		send_element(pos, -32'sd5, 1'b1, 7'h00, int'(ElemPoints));
		send_request(CmdSample, 1'b0, pos, 1'b1);
		wait_drain();
		write_mode(1'b0);
		mode_now = 1'b0;

		// ---- random part ----
		rough         = 1'b1;
		counted_items = 0;
		next_hold     = 100;
		next_drain    = 200;
		while (counted_items < 950) begin
			if (counted_items < 317) begin
				send_idle_pct = 6;
				recv_idle_pct = 50;
			end else if (counted_items < 634) begin
				send_idle_pct = 50;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// result side stops for a while, requests keep coming and back up
			if (counted_items >= next_hold) begin
				-> hold_off_ev;
				next_hold += 330;
			end
			// request side pauses until all owed results are back
			if (counted_items >= next_drain) begin
				wait_drain();
				next_drain += 200;
			end
			dbl = 1'($urandom_range(1));
			if (dbl != mode_now) begin
				wait_drain();
				write_mode(dbl);
				mode_now = dbl;
			end
			if ($urandom_range(99) < 75) begin
				// well-formed read with random content; some cut short and re-armed
				iv  = pick_interval();
				pos = $urandom;
				send_request(CmdArm, 1'($urandom_range(1)), $urandom, 1'b1);
				send_bars(pos, iv);
				points = ($urandom_range(7) == 0) ? $urandom_range(1, 7) : int'(ElemPoints);
				send_element(pos, iv, 1'b0, ElemW'($urandom), points);
				if (dbl && points == int'(ElemPoints)) begin
					if ($urandom_range(1)) iv = pick_interval();
					send_bars(pos, iv);
					send_element(pos, iv, 1'b1, ElemW'($urandom), int'(ElemPoints));
				end
				// samples after the read leave the reported code in place
				repeat ($urandom_range(2))
					send_request(CmdSample, 1'($urandom_range(1)), pos, 1'b0);
			end else begin
				// noise: stray arms and samples
				repeat ($urandom_range(1, 6))
					send_request(($urandom_range(3) == 0) ? CmdArm : CmdSample,
						1'($urandom_range(1)), $urandom, 1'b1);
			end
		end

		wait_drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[position_sampled_barcode_reader_unit.f]
rtl/core/psbr_pkg.sv
rtl/core/psbr_if.sv
rtl/core/position_sampled_barcode_reader_unit.sv
bench/tb_top.sv
